FILE: hdl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types, codes and sizes for the multi-cell charge controller.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int SLOTS        = 4;
  localparam int SAMPLES_LOG2 = 4;
  localparam int SAMPLES      = 1 << SAMPLES_LOG2;

  localparam int SMP_W      = 10;
  localparam int SUM_W      = SMP_W + SAMPLES_LOG2;
  localparam int CNT_W      = SAMPLES_LOG2;
  localparam int SLOT_W     = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int SLOT_OUT_W = 2;
  localparam int SLOT_PAD_W = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;
  localparam int MASK_OUT_W = 4;
  localparam int MASK_PAD_W = (SLOTS > MASK_OUT_W) ? SLOTS : MASK_OUT_W;
  localparam int BAR_W      = 5;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int REG_W  = 3;

  localparam logic [REG_W-1:0] REG_EMPTY      = 3'd0;
  localparam logic [REG_W-1:0] REG_BAD        = 3'd1;
  localparam logic [REG_W-1:0] REG_STOP       = 3'd2;
  localparam logic [REG_W-1:0] REG_HOLD       = 3'd3;
  localparam logic [REG_W-1:0] REG_BAR_ONE    = 3'd4;
  localparam logic [REG_W-1:0] REG_BAR_TWO    = 3'd5;
  localparam logic [REG_W-1:0] REG_BAR_THREE  = 3'd6;

  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_TICK     = 1'b1;
  localparam logic KIND_DRIVE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [BAR_W-1:0] BAR_NONE = 5'b00000;
  localparam logic [BAR_W-1:0] BAR_BAD  = 5'b00001;
  localparam logic [BAR_W-1:0] BAR_FULL = 5'b10000;

  typedef enum logic [1:0] {
    VERDICT_NONE     = 2'd0,
    VERDICT_BAD      = 2'd1,
    VERDICT_FULL     = 2'd2,
    VERDICT_CHARGING = 2'd3
  } mcc_verdict_e;

  typedef struct packed {
    logic [SMP_W-1:0] empty_limit;
    logic [SMP_W-1:0] bad_limit;
    logic [SMP_W-1:0] stop_limit;
    logic [SMP_W-1:0] hold_limit;
    logic [SMP_W-1:0] bar_step_one;
    logic [SMP_W-1:0] bar_step_two;
    logic [SMP_W-1:0] bar_step_three;
  } mcc_cfg_t;

  typedef struct packed {
    mcc_verdict_e     verdict;
    logic [BAR_W-1:0] bar;
  } mcc_class_t;

  function automatic logic [SLOTS-1:0] even_slots();
    logic [SLOTS-1:0] m;
    for (int i = 0; i < SLOTS; i++) begin
      m[i] = ((i % 2) == 0);
    end
    return m;
  endfunction

endpackage

FILE: hdl/mcc_classify.sv
// ----------------------------------------------------------------------------
// mcc_classify
// Sorts an averaged reading into no cell, bad, full or charging and builds
// the bar pattern.
// ----------------------------------------------------------------------------
module mcc_classify import mcc_pkg::*; (
  input  logic [SMP_W-1:0] average_i,
  input  logic             charged_i,
  input  mcc_cfg_t         cfg_i,
  output mcc_class_t       class_o
);

  logic [BAR_W-1:0] bar_level;

  always_comb begin
    bar_level    = BAR_BAD;
    bar_level[1] = (average_i >= cfg_i.bar_step_one);
    bar_level[2] = (average_i >= cfg_i.bar_step_two);
    bar_level[3] = (average_i >= cfg_i.bar_step_three);
    bar_level[4] = (average_i >= cfg_i.hold_limit);
  end

  always_comb begin
    if (average_i <= cfg_i.empty_limit) begin
      class_o.verdict = VERDICT_NONE;
      class_o.bar     = BAR_NONE;
    end else if (average_i < cfg_i.bad_limit) begin
      class_o.verdict = VERDICT_BAD;
      class_o.bar     = BAR_BAD;
    end else if ((average_i >= cfg_i.stop_limit) ||
                 ((average_i > cfg_i.hold_limit) && charged_i)) begin
      class_o.verdict = VERDICT_FULL;
      class_o.bar     = BAR_FULL;
    end else begin
      class_o.verdict = VERDICT_CHARGING;
      class_o.bar     = bar_level;
    end
  end

endmodule

FILE: hdl/multi_cell_charge_controller.sv
// ----------------------------------------------------------------------------
// multi_cell_charge_controller
// Round-robin charge controller: averages converter samples per slot,
// classifies each cell, keeps charging and charged masks and gives
// alternating even/odd pulse drives on timer ticks.
// ----------------------------------------------------------------------------
// channel  | handshake                  | payload
// in       | in_valid_i / in_ready_o    | operation_i, sample_i
// out      | out_valid_o / out_ready_i  | kind_o, drive_o, slot_o, average_o,
//          |                            | verdict_o, bar_pattern_o,
//          |                            | charging_bits_o, charged_bits_o
// cfg      | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// one item per cycle while no result is held up at the output; an item passes
// the input register, then the result register
// the sixteenth sample of a measurement gives a report, a tick a drive update
// reset clears the accumulator, masks, slot and phase and loads the limits
// an item whose result cannot leave holds the input register; the result
// register drains while the next item is taken
// ----------------------------------------------------------------------------
module multi_cell_charge_controller import mcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [SMP_W-1:0]      sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  kind_o,
  output logic [MASK_OUT_W-1:0] drive_o,
  output logic [SLOT_OUT_W-1:0] slot_o,
  output logic [SMP_W-1:0]      average_o,
  output logic [1:0]            verdict_o,
  output logic [BAR_W-1:0]      bar_pattern_o,
  output logic [MASK_OUT_W-1:0] charging_bits_o,
  output logic [MASK_OUT_W-1:0] charged_bits_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  localparam logic [SLOTS-1:0] EVEN_MASK = even_slots();
  localparam logic [SLOTS-1:0] ODD_MASK  = ~EVEN_MASK;
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(SAMPLES - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // configuration
  mcc_cfg_t         cfg_q;
  logic             cfg_wr;
  logic [REG_W-1:0] cfg_idx;
  logic [SMP_W-1:0] rd_val;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.empty_limit    <= 10'd32;
      cfg_q.bad_limit      <= 10'd424;
      cfg_q.stop_limit     <= 10'd894;
      cfg_q.hold_limit     <= 10'd838;
      cfg_q.bar_step_one   <= 10'd682;
      cfg_q.bar_step_two   <= 10'd735;
      cfg_q.bar_step_three <= 10'd786;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_EMPTY:     cfg_q.empty_limit    <= pwdata[SMP_W-1:0];
        REG_BAD:       cfg_q.bad_limit      <= pwdata[SMP_W-1:0];
        REG_STOP:      cfg_q.stop_limit     <= pwdata[SMP_W-1:0];
        REG_HOLD:      cfg_q.hold_limit     <= pwdata[SMP_W-1:0];
        REG_BAR_ONE:   cfg_q.bar_step_one   <= pwdata[SMP_W-1:0];
        REG_BAR_TWO:   cfg_q.bar_step_two   <= pwdata[SMP_W-1:0];
        REG_BAR_THREE: cfg_q.bar_step_three <= pwdata[SMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_EMPTY:     rd_val = cfg_q.empty_limit;
      REG_BAD:       rd_val = cfg_q.bad_limit;
      REG_STOP:      rd_val = cfg_q.stop_limit;
      REG_HOLD:      rd_val = cfg_q.hold_limit;
      REG_BAR_ONE:   rd_val = cfg_q.bar_step_one;
      REG_BAR_TWO:   rd_val = cfg_q.bar_step_two;
      REG_BAR_THREE: rd_val = cfg_q.bar_step_three;
      default:       rd_val = '0;
    endcase
  end

  assign prdata = APB_DW'(rd_val);

  // input register
  logic             s1_valid_q;
  logic             s1_op_q;
  logic [SMP_W-1:0] s1_smp_q;

  // controller state
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOTS-1:0]  charging_q, charging_d;
  logic [SLOTS-1:0]  charged_q, charged_d;
  logic              phase_q, phase_d;

  // result register
  logic              res_valid_q;
  logic              res_kind_q;
  logic [SLOTS-1:0]  res_drive_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [SMP_W-1:0]  res_avg_q;
  mcc_verdict_e      res_verdict_q;
  logic [BAR_W-1:0]  res_bar_q;
  logic [SLOTS-1:0]  res_charging_q;
  logic [SLOTS-1:0]  res_charged_q;

  logic             is_tick, last_smp, has_res, out_free, s1_go;
  logic [SUM_W-1:0] sum_next;
  logic [SMP_W-1:0] avg;
  logic [SLOTS-1:0] slot_bit;
  logic [SLOTS-1:0] tick_drive;
  mcc_class_t       cls;

  assign is_tick  = (s1_op_q == OP_TICK);
  assign last_smp = !is_tick && (cnt_q == LAST_CNT);
  assign has_res  = is_tick || last_smp;
  assign out_free = !res_valid_q || out_ready_i;
  assign s1_go    = s1_valid_q && (!has_res || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  assign sum_next = sum_q + SUM_W'(s1_smp_q);
  assign avg      = sum_next[SUM_W-1:SAMPLES_LOG2];
  assign slot_bit = SLOTS'(1) << slot_q;

  mcc_classify u_classify (
    .average_i (avg),
    .charged_i ((charged_q & slot_bit) != '0),
    .cfg_i     (cfg_q),
    .class_o   (cls)
  );

  always_comb begin
    tick_drive = '0;
    if (cnt_q == '0) begin
      tick_drive = charging_q & (phase_q ? EVEN_MASK : ODD_MASK);
    end
  end

  always_comb begin
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    slot_d     = slot_q;
    charging_d = charging_q;
    charged_d  = charged_q;
    phase_d    = phase_q;
    if (is_tick) begin
      if (cnt_q == '0) begin
        phase_d = !phase_q;
      end
    end else if (last_smp) begin
      sum_d      = '0;
      cnt_d      = '0;
      slot_d     = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
      charging_d = charging_q & ~slot_bit;
      case (cls.verdict)
        VERDICT_FULL:     charged_d = charged_q | slot_bit;
        VERDICT_CHARGING: begin
          charging_d = (charging_q & ~slot_bit) | slot_bit;
          charged_d  = charged_q & ~slot_bit;
        end
        default:          charged_d = charged_q & ~slot_bit;
      endcase
    end else begin
      sum_d = sum_next;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      slot_q      <= '0;
      charging_q  <= '0;
      charged_q   <= '0;
      phase_q     <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_go && has_res) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (s1_go) begin
        sum_q      <= sum_d;
        cnt_q      <= cnt_d;
        slot_q     <= slot_d;
        charging_q <= charging_d;
        charged_q  <= charged_d;
        phase_q    <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q  <= operation_i;
      s1_smp_q <= sample_i;
    end
    if (s1_go && has_res) begin
      res_charging_q <= charging_d;
      res_charged_q  <= charged_d;
      if (is_tick) begin
        res_kind_q    <= KIND_DRIVE;
        res_drive_q   <= tick_drive;
        res_slot_q    <= '0;
        res_avg_q     <= '0;
        res_verdict_q <= VERDICT_NONE;
        res_bar_q     <= BAR_NONE;
      end else begin
        res_kind_q    <= KIND_REPORT;
        res_drive_q   <= '0;
        res_slot_q    <= slot_q;
        res_avg_q     <= avg;
        res_verdict_q <= cls.verdict;
        res_bar_q     <= cls.bar;
      end
    end
  end

  logic [MASK_PAD_W-1:0] drive_pad, charging_pad, charged_pad;
  logic [SLOT_PAD_W-1:0] slot_pad;

  assign drive_pad    = MASK_PAD_W'(res_drive_q);
  assign charging_pad = MASK_PAD_W'(res_charging_q);
  assign charged_pad  = MASK_PAD_W'(res_charged_q);
  assign slot_pad     = SLOT_PAD_W'(res_slot_q);

  assign out_valid_o     = res_valid_q;
  assign kind_o          = res_kind_q;
  assign drive_o         = drive_pad[MASK_OUT_W-1:0];
  assign slot_o          = slot_pad[SLOT_OUT_W-1:0];
  assign average_o       = res_avg_q;
  assign verdict_o       = res_verdict_q;
  assign bar_pattern_o   = res_bar_q;
  assign charging_bits_o = charging_pad[MASK_OUT_W-1:0];
  assign charged_bits_o  = charged_pad[MASK_OUT_W-1:0];

  // a cell is never charging and charged at once
  a_masks_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (charging_q & charged_q) == '0)
    else $error("charging and charged masks overlap");

  // drives only go to slots that are charging
  a_drive_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DRIVE) |-> (drive_o & ~charging_bits_o) == '0)
    else $error("drive on a slot that is not charging");

  // reports carry no drive
  a_report_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_REPORT) |-> drive_o == '0)
    else $error("report with drive bits");

  // pulse timer stands still during a measurement
  a_tick_in_measure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && is_tick && (cnt_q != '0) |=> (res_drive_q == '0) && $stable(phase_q))
    else $error("drive given during a measurement");

endmodule
